@@ hw/rtl/lsag_pkg.sv @@
// Shared types and constants for the Legendre shifted-array generator.
// Used by lsag_modred, lsag_map and legendre_shift_array_gen_top; no dependencies.

package lsag_pkg;

  // Operand width of the serial reducer: a 17-bit sum padded to an even width.
  localparam int RED_W             = 18;
  localparam int RED_BITS_PER_STEP = 2;
  localparam int RED_STEPS         = RED_W / RED_BITS_PER_STEP;
  localparam int RED_CW            = $clog2(RED_STEPS);

  // Register indexes, decoded from address bit 2.
  localparam logic REG_PRIME = 1'b0;
  localparam logic REG_SHIFT = 1'b1;

  localparam logic [7:0] PRIME_RST = 8'd7;
  localparam logic [7:0] SHIFT_RST = 8'd1;

  // Element codes: +1 and -1 in two-bit two's complement.
  localparam logic [1:0] VAL_POS = 2'b01;
  localparam logic [1:0] VAL_NEG = 2'b11;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MARK,
    PH_EMIT,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic             start;
    logic [RED_W-1:0] operand;
    logic [7:0]       modulus;
  } red_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] rem;
  } red_resp_t;

  typedef struct packed {
    logic       clear;
    logic       set_en;
    logic [7:0] set_idx;
  } map_ctrl_t;

endpackage

@@ hw/rtl/lsag_modred.sv @@
// Shared serial modular reducer: operand mod modulus, two bits per cycle.
// Depends on lsag_pkg for widths and the request/response structs.

module lsag_modred
  import lsag_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  red_req_t  req,
  output red_resp_t resp
);

  logic [RED_W-1:0]  sh_r;
  logic [7:0]        rem_r;
  logic [7:0]        rem_nxt;
  logic [7:0]        mod_r;
  logic [RED_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  // Restoring step: remainder stays below the modulus, so 2r+b needs one subtract.
  always_comb begin
    logic [8:0] acc;
    logic [7:0] rr;
    rr  = rem_r;
    acc = '0;
    for (int s = 0; s < RED_BITS_PER_STEP; s++) begin
      acc = {rr, sh_r[RED_W-1-s]};
      if (acc >= {1'b0, mod_r}) begin
        acc = acc - {1'b0, mod_r};
      end
      rr = acc[7:0];
    end
    rem_nxt = rr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == RED_CW'(RED_STEPS - 1));
      if (busy_r) begin
        sh_r  <= sh_r << RED_BITS_PER_STEP;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + RED_CW'(1);
        if (cnt_r == RED_CW'(RED_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end else if (req.start) begin
        sh_r   <= req.operand;
        mod_r  <= req.modulus;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end
    end
  end

  assign resp.done = done_r;
  assign resp.rem  = rem_r;

endmodule

@@ hw/rtl/lsag_map.sv @@
// Residue map: one flag per residue in a memory with a registered read port.
// Cleared by a pass over every entry after reset or restart; depends on lsag_pkg.

module lsag_map
  import lsag_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  map_ctrl_t ctrl,
  input  logic [7:0] rd_idx,
  output logic      rd_bit,
  output logic      clr_busy
);

  localparam int AW = $clog2(DEPTH);

  logic          map_r [DEPTH];
  logic [AW-1:0] clr_idx_r;
  logic          clr_busy_r;
  logic          rd_bit_r;
  logic          set_ok;
  logic          rd_ok;
  logic          wr_en;
  logic [AW-1:0] wr_idx;
  logic          wr_bit;

  // Indexes past the store drop the write and read as clear.
  assign set_ok = {1'b0, ctrl.set_idx} < 9'(DEPTH);
  assign rd_ok  = {1'b0, rd_idx} < 9'(DEPTH);

  // The clearing pass owns the write port while it runs.
  assign wr_en  = clr_busy_r || (ctrl.set_en && set_ok);
  assign wr_idx = clr_busy_r ? clr_idx_r : ctrl.set_idx[AW-1:0];
  assign wr_bit = !clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (ctrl.clear) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + AW'(1);
      if (clr_idx_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_r[wr_idx] <= wr_bit;
    end
    rd_bit_r <= rd_ok && map_r[rd_idx[AW-1:0]];
  end

  assign rd_bit   = rd_bit_r;
  assign clr_busy = clr_busy_r;

endmodule

@@ hw/rtl/legendre_shift_array_gen_top.sv @@
// Top level of the Legendre shifted-array generator: registers, sequencer, output stage.
// Depends on lsag_pkg, lsag_modred and lsag_map.
//
// Usage: program prime_modulus (byte address 0) and shift_factor (byte address 4)
// over the APB port while the block is idle; only paddr[2] selects the register.
// Each input word carries one tick in in_tdata[0]: 1 restarts, 0 advances.
// A restart clears the residue map by writing every entry, one per cycle, and
// in_tready stays low until that clearing pass is through. Ticks in idle or done
// are taken one per cycle and give no word. A mark tick runs the shared reducer
// once (m*m mod p). An emit tick runs it twice (i*i mod p, then sq*k + j mod p)
// and loads its word once the output stage is free. The next tick is taken only
// after the reducer work for the last one is done and any word is loaded. The
// reducer handles two operand bits per cycle over 18 bits. Elements leave in
// row-major order, tlast on the final one.
// in_tready is high only while the sequencer waits; a stalled out_tready holds
// the output word, and the next result waits until it is taken. A new tick is
// accepted while an earlier word still waits. Reset restores the register
// defaults, clears the counters and the phase and starts the same clearing pass.

module legendre_shift_array_gen_top
  import lsag_pkg::*;
#(
  parameter int MAX_PRIME = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [0] restart
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // out_tdata: [1:0] value, [9:2] row_index, [17:10] col_index, [23:18] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int MAP_DEPTH = (MAX_PRIME < 256) ? MAX_PRIME : 256;

  typedef enum logic [2:0] {
    S_CLR,
    S_WAIT,
    S_MARK,
    S_SQ,
    S_IDX,
    S_OUT
  } state_t;

  logic [7:0] prime_r;
  logic [7:0] shift_r;

  state_t           state_r;
  phase_t           phase_r;
  logic [7:0]       mark_cnt_r;
  logic [7:0]       row_r;
  logic [7:0]       col_r;
  logic             red_start_r;
  logic [RED_W-1:0] red_op_r;

  logic       out_tvalid_r;
  logic [1:0] out_value_r;
  logic [7:0] out_row_r;
  logic [7:0] out_col_r;
  logic       out_last_r;

  red_req_t  red_req;
  red_resp_t red_resp;
  map_ctrl_t map_ctrl;
  logic      map_bit;
  logic      map_busy;

  logic        in_acc;
  logic        cfg_wr;
  logic        red_go;
  logic [8:0]  p9;
  logic [15:0] mark_sq;
  logic [15:0] col_sq;
  logic [16:0] idx_sum;
  logic        mark_end;
  logic        col_end;
  logic        row_end;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_SHIFT) ? {24'd0, shift_r} : {24'd0, prime_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r <= PRIME_RST;
      shift_r <= SHIFT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_PRIME) begin
        prime_r <= cfg_pwdata[7:0];
      end else begin
        shift_r <= cfg_pwdata[7:0];
      end
    end
  end

  // Operands and end tests
  assign in_tready = (state_r == S_WAIT);
  assign in_acc    = in_tvalid && in_tready;
  assign p9        = {1'b0, prime_r};
  assign mark_sq   = {8'd0, mark_cnt_r} * {8'd0, mark_cnt_r};
  assign col_sq    = {8'd0, col_r} * {8'd0, col_r};
  assign idx_sum   = {1'b0, {8'd0, red_resp.rem} * {8'd0, shift_r}} + {9'd0, row_r};
  assign mark_end  = ({1'b0, mark_cnt_r} + 9'd1) >= p9;
  assign col_end   = ({1'b0, col_r} + 9'd1) >= p9;
  assign row_end   = ({1'b0, row_r} + 9'd1) >= p9;

  // Launch the reducer for an advance tick in mark or emit, and for the second emit pass.
  assign red_go = (in_acc && !in_tdata[0] && (prime_r != 8'd0) &&
                   (phase_r == PH_MARK || phase_r == PH_EMIT)) ||
                  ((state_r == S_SQ) && red_resp.done);

  assign red_req.start   = red_start_r;
  assign red_req.operand = red_op_r;
  assign red_req.modulus = prime_r;

  assign map_ctrl.clear   = in_acc && in_tdata[0];
  assign map_ctrl.set_en  = (state_r == S_MARK) && red_resp.done;
  assign map_ctrl.set_idx = red_resp.rem;

  lsag_modred u_modred (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (red_req),
    .resp  (red_resp)
  );

  lsag_map #(
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (map_ctrl),
    .rd_idx   (red_resp.rem),
    .rd_bit   (map_bit),
    .clr_busy (map_busy)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      phase_r      <= PH_IDLE;
      mark_cnt_r   <= '0;
      row_r        <= '0;
      col_r        <= '0;
      red_start_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      red_start_r <= red_go;
      // drop the taken word unless the output state reloads it this cycle
      if (out_tvalid_r && out_tready && state_r != S_OUT) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          // hold off ticks until every map entry is written clear
          if (!map_busy) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (in_acc) begin
            if (in_tdata[0]) begin
              mark_cnt_r <= '0;
              row_r      <= '0;
              col_r      <= '0;
              phase_r    <= (prime_r == 8'd0) ? PH_DONE : PH_MARK;
              state_r    <= S_CLR;
            end else if (phase_r == PH_MARK || phase_r == PH_EMIT) begin
              if (prime_r == 8'd0) begin
                phase_r <= PH_DONE;
              end else if (phase_r == PH_MARK) begin
                red_op_r <= RED_W'(mark_sq);
                state_r  <= S_MARK;
              end else begin
                red_op_r <= RED_W'(col_sq);
                state_r  <= S_SQ;
              end
            end
          end
        end
        S_MARK: begin
          if (red_resp.done) begin
            if (mark_end) begin
              phase_r <= PH_EMIT;
              row_r   <= '0;
              col_r   <= '0;
            end else begin
              mark_cnt_r <= mark_cnt_r + 8'd1;
            end
            state_r <= S_WAIT;
          end
        end
        S_SQ: begin
          // remainder is i*i mod p; chain sq*k + j into the second pass
          if (red_resp.done) begin
            red_op_r <= RED_W'(idx_sum);
            state_r  <= S_IDX;
          end
        end
        S_IDX: begin
          if (red_resp.done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output stage is free; the map read stays put while the
          // reducer idles
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_value_r  <= map_bit ? VAL_POS : VAL_NEG;
            out_row_r    <= row_r;
            out_col_r    <= col_r;
            out_last_r   <= col_end && row_end;
            if (col_end && row_end) begin
              phase_r <= PH_DONE;
            end else if (col_end) begin
              col_r <= '0;
              row_r <= row_r + 8'd1;
            end else begin
              col_r <= col_r + 8'd1;
            end
            state_r <= S_WAIT;
          end
        end
        default: begin
          state_r <= S_WAIT;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, out_col_r, out_row_r, out_value_r};
  assign out_tlast  = out_last_r;

endmodule

@@ dv/tb_top.sv @@
// Self-checking bench for legendre_shift_array_gen_top: an array checker predicts each
// element word from the ticks taken in and the live register values.
// Depends on lsag_pkg and the top level; drives the stream and APB ports with plain tasks.

module tb_top
  import lsag_pkg::*;
();

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int TICK_TARGET   = 600;

  typedef struct packed {
    logic [1:0] value;
    logic [7:0] row;
    logic [7:0] col;
    logic       last;
  } element_t;

  class array_checker;
    int unsigned prime;
    int unsigned shift;
    phase_t      gen_phase;
    logic [7:0]  mark_cnt;
    logic [7:0]  row_cnt;
    logic [7:0]  col_cnt;
    logic [255:0] squares;
    element_t    expected_q[$];
    int          errors;

    function new();
      prime     = PRIME_RST;
      shift     = SHIFT_RST;
      gen_phase = PH_IDLE;
      mark_cnt  = '0;
      row_cnt   = '0;
      col_cnt   = '0;
      squares   = '0;
      errors    = 0;
    endfunction

    function void set_reg(logic idx, logic [7:0] val);
      if (idx == REG_PRIME) begin
        prime = val;
      end else begin
        shift = val;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the generator by one tick; queue the element word it yields, if any.
    function void note_tick(bit restart);
      int unsigned m, im, sq, sh, idx, i, j;
      bit          is_last;
      element_t    e;
      if (restart) begin
        squares   = '0;
        mark_cnt  = '0;
        row_cnt   = '0;
        col_cnt   = '0;
        gen_phase = (prime == 0) ? PH_DONE : PH_MARK;
        return;
      end
      if (gen_phase == PH_IDLE || gen_phase == PH_DONE) return;
      if (prime == 0) begin
        gen_phase = PH_DONE;
        return;
      end
      if (gen_phase == PH_MARK) begin
        m = mark_cnt % prime;
        squares[(m * m) % prime] = 1'b1;
        if (mark_cnt + 1 >= prime) begin
          gen_phase = PH_EMIT;
          row_cnt   = '0;
          col_cnt   = '0;
        end else begin
          mark_cnt = mark_cnt + 8'd1;
        end
        return;
      end
      i       = col_cnt;
      j       = row_cnt;
      im      = i % prime;
      sq      = (im * im) % prime;
      sh      = (sq * (shift % prime)) % prime;
      idx     = ((j % prime) + sh) % prime;
      is_last = (i + 1 >= prime) && (j + 1 >= prime);
      e.value = squares[idx] ? VAL_POS : VAL_NEG;
      e.row   = row_cnt;
      e.col   = col_cnt;
      e.last  = is_last;
      expected_q.push_back(e);
      if (is_last) begin
        gen_phase = PH_DONE;
      end else if (i + 1 >= prime) begin
        col_cnt = '0;
        row_cnt = row_cnt + 8'd1;
      end else begin
        col_cnt = col_cnt + 8'd1;
      end
    endfunction

    task flag_mismatch(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_element(logic [23:0] data, logic last);
      element_t want;
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected word row %0d col %0d", data[9:2], data[17:10]));
        return;
      end
      want = expected_q.pop_front();
      if (data[1:0] !== want.value)
        flag_mismatch($sformatf("value %b, want %b at row %0d col %0d",
                                data[1:0], want.value, want.row, want.col));
      if (data[9:2] !== want.row)
        flag_mismatch($sformatf("row_index %0d, want %0d", data[9:2], want.row));
      if (data[17:10] !== want.col)
        flag_mismatch($sformatf("col_index %0d, want %0d", data[17:10], want.col));
      if (last !== want.last)
        flag_mismatch($sformatf("tlast %b, want %b at row %0d col %0d",
                                last, want.last, want.row, want.col));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // [0] restart, [7:1] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;    // [1:0] value, [9:2] row_index, [17:10] col_index, [23:18] zero
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  array_checker sb;
  int send_gap_pct;
  int ready_stall_pct;
  int ticks_sent;
  int quiet_cycles;
  int hold_left;
  bit hold_req;

  legendre_shift_array_gen_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Result side: check each taken word, then pick tready for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_element(out_tdata, out_tlast);
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(bit restart);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, restart};
    do @(posedge clk); while (!in_tready);
    sb.note_tick(restart);
    ticks_sent++;
  endtask

  task automatic tick_run(bit restart, int advances);
    if (restart) send_tick(1'b1);
    repeat (advances) send_tick(1'b0);
  endtask

  // Drain all expected words, let a pending mark tick finish, then wait for the sequencer.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Write one register, then read it back.
  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, val);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {24'd0, val})
      sb.flag_mismatch($sformatf("register %0d reads %h, want %h", idx, cfg_prdata, val));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin
    int unsigned p;
    int unsigned n;
    logic [7:0]  k;
    bit          continue_run;
    int          chunk;
    sb              = new();
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    send_gap_pct    = 0;
    ready_stall_pct = 0;
    ticks_sent      = 0;
    hold_req        = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: advance while idle, a full 2x2 array with tick in done,
    // restart in mid-run, 1x1 array with k above p, zero modulus, big p.
    tick_run(1'b0, 1);
    wait_idle();
    write_reg(REG_PRIME, 8'd2);
    write_reg(REG_SHIFT, 8'd0);
    tick_run(1'b1, 7);
    tick_run(1'b1, 3);
    tick_run(1'b1, 0);
    wait_idle();
    write_reg(REG_PRIME, 8'd1);
    write_reg(REG_SHIFT, 8'd200);
    tick_run(1'b1, 3);
    wait_idle();
    write_reg(REG_PRIME, 8'd0);
    tick_run(1'b1, 1);
    wait_idle();
    write_reg(REG_PRIME, 8'd3);
    tick_run(1'b1, 1);
    wait_idle();
    write_reg(REG_PRIME, 8'd0);
    tick_run(1'b0, 1);
    wait_idle();
    write_reg(REG_PRIME, 8'd255);
    write_reg(REG_SHIFT, 8'd254);
    tick_run(1'b1, 2);

    // Random: mostly whole small arrays, one large run, some live register changes
    // and stray restarts.
    chunk = 0;
    while (ticks_sent < TICK_TARGET) begin
      case (chunk % 4)
        0: begin send_gap_pct = 0;  ready_stall_pct = 0;  end
        1: begin send_gap_pct = 75; ready_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  ready_stall_pct = 75; end
        default: begin send_gap_pct = 26; ready_stall_pct = 26; end
      endcase
      wait_idle();
      continue_run = (chunk != 2) && (chunk != 5) && ($urandom_range(0, 4) == 0);
      if (chunk == 5) begin
        p = $urandom_range(200, 255);
        n = p + $urandom_range(5, 30);
      end else if (chunk == 2) begin
        p = $urandom_range(5, 11);
        n = p + p * p;
      end else if (continue_run) begin
        p = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(2, 13);
        n = $urandom_range(1, 30);
      end else begin
        p = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 13);
        n = p + p * p + $urandom_range(0, 3);
      end
      k = $urandom_range(0, 255);
      write_reg(REG_PRIME, p[7:0]);
      write_reg(REG_SHIFT, k);
      if (!continue_run) send_tick(1'b1);
      // Hold off the result side so the block fills up and stalls its input.
      if (chunk == 2) hold_req = 1'b1;
      repeat (n) send_tick($urandom_range(0, 49) == 0);
      chunk++;
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
